/* sv/dtp_pkg.sv */
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, constants and character helpers for the duration text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // Width of the internal arithmetic; all sums wrap at this width.
  localparam int VALUE_BITS  = 32;
  // Width of the result field on the output channel.
  localparam int OUT_BITS    = 32;

  // Time constants.
  localparam int MUL_WEEK    = 7;
  localparam int MUL_YEAR    = 365;
  localparam int HOURS_DAY   = 24;
  localparam int SIXTY       = 60;
  localparam int RADIX       = 10;
  localparam int SEC_MIN     = SIXTY;
  localparam int SEC_HOUR    = SIXTY * SIXTY;
  localparam int SEC_DAY     = HOURS_DAY * SEC_HOUR;
  localparam int SEC_WEEK    = MUL_WEEK * SEC_DAY;
  localparam int SEC_YEAR    = MUL_YEAR * SEC_DAY;
  // Wide enough for the largest unit factor (one year in seconds).
  localparam int FACTOR_BITS = $clog2(SEC_YEAR + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LW    = 8'h77;
  localparam logic [7:0] CH_LY    = 8'h79;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_LEAD,
    PH_NUM,
    PH_POSTWS,
    PH_WORD,
    PH_SEPWS,
    PH_A,
    PH_AN,
    PH_AND,
    PH_SKIP
  } phase_t;

  // Time units.
  typedef enum logic [2:0] {
    U_NONE,
    U_SEC,
    U_MIN,
    U_HOUR,
    U_DAY,
    U_WEEK,
    U_YEAR
  } unit_t;

  // One parsed byte as seen by the scaling stage.
  typedef struct packed {
    logic                  add;   // a term is complete and must be summed
    logic                  last;  // end of text
    logic                  ok;    // text well formed (meaningful with last)
    unit_t                 unit;
    logic [VALUE_BITS-1:0] term;  // term with its sign applied
  } event_t;

  // One scaled term as seen by the accumulator.
  typedef struct packed {
    logic                  last;
    logic                  ok;
    logic [VALUE_BITS-1:0] value;
  } prod_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  // Folding the case bit only maps upper-case letters onto the unit letters.
  function automatic unit_t unit_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    case (lc)
      CH_LS:   return U_SEC;
      CH_LM:   return U_MIN;
      CH_LH:   return U_HOUR;
      CH_LD:   return U_DAY;
      CH_LW:   return U_WEEK;
      CH_LY:   return U_YEAR;
      default: return U_NONE;
    endcase
  endfunction

  function automatic logic [FACTOR_BITS-1:0] unit_factor(input unit_t u);
    case (u)
      U_SEC:   return FACTOR_BITS'(1);
      U_MIN:   return FACTOR_BITS'(SEC_MIN);
      U_HOUR:  return FACTOR_BITS'(SEC_HOUR);
      U_DAY:   return FACTOR_BITS'(SEC_DAY);
      U_WEEK:  return FACTOR_BITS'(SEC_WEEK);
      U_YEAR:  return FACTOR_BITS'(SEC_YEAR);
      default: return '0;
    endcase
  endfunction

  // Sign-extend or cut the internal value to the output field width.
  function automatic logic signed [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
    return OUT_BITS'(signed'(v));
  endfunction

endpackage

/* sv/dtp_byte_if.sv */
// ----------------------------------------------------------------------------
// dtp_byte_if
// Valid/ready channel carrying one text byte per transaction.
// ----------------------------------------------------------------------------
interface dtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

/* sv/dtp_result_if.sv */
// ----------------------------------------------------------------------------
// dtp_result_if
// Valid/ready channel carrying one parse result per transaction.
// ----------------------------------------------------------------------------
interface dtp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] total_seconds;
  logic               parse_error;

  modport source (output valid, output total_seconds, output parse_error, input ready);
  modport sink   (input valid, input total_seconds, input parse_error, output ready);
endinterface

/* sv/dtp_parser.sv */
// ----------------------------------------------------------------------------
// dtp_parser
// Character state machine: takes one byte per cycle unless back-pressured;
// builds the term value and hands completed terms and end markers to scaling.
// ----------------------------------------------------------------------------
module dtp_parser (
  input  logic            clk,
  input  logic            rst,
  dtp_byte_if.sink        text,
  output dtp_pkg::event_t ev,
  output logic            ev_valid,
  input  logic            ev_ready
);
  import dtp_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  logic                  negative_term;
  logic                  digits_seen;
  logic [VALUE_BITS-1:0] term_value;
  logic                  error_seen;

  logic [7:0]            c;
  logic                  accept;
  logic                  at_end;
  logic                  c_ws;
  logic                  c_digit;
  logic                  c_letter;
  logic                  c_starts;
  unit_t                 c_unit;
  logic                  c_has_unit;
  logic [VALUE_BITS-1:0] c_val;
  logic                  act_begin;
  logic                  act_digit;
  logic                  act_unit;
  logic                  fin_add;
  logic                  fin_ok;
  logic [VALUE_BITS-1:0] term_digit;
  logic [VALUE_BITS-1:0] term_signed;

  // Byte classification.
  assign c          = text.text_byte;
  assign at_end     = (c == CH_NUL);
  assign c_ws       = is_ws(c);
  assign c_digit    = is_digit(c);
  assign c_letter   = is_letter(c);
  assign c_starts   = c_digit || (c == CH_PLUS) || (c == CH_MINUS);
  assign c_unit     = unit_of(c);
  assign c_has_unit = (c_unit != U_NONE);
  assign c_val      = VALUE_BITS'(c[3:0]);

  // The stage takes a byte whenever its event register is free or draining.
  assign text.ready = !ev_valid || ev_ready;
  assign accept     = text.valid && text.ready;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (at_end) begin
      phase_next = PH_LEAD;
    end else begin
      case (phase)
        PH_LEAD: begin
          if (!c_ws) phase_next = c_starts ? PH_NUM : PH_SKIP;
        end
        PH_NUM: begin
          if (!c_digit) begin
            if (!digits_seen)    phase_next = PH_SKIP;
            else if (c_ws)       phase_next = PH_POSTWS;
            else if (c_has_unit) phase_next = PH_WORD;
            else                 phase_next = PH_SKIP;
          end
        end
        PH_POSTWS: begin
          if (!c_ws) phase_next = c_has_unit ? PH_WORD : PH_SKIP;
        end
        PH_WORD: begin
          if (!c_letter) begin
            if (c == CH_COMMA || c_ws) phase_next = PH_SEPWS;
            else if (c_starts)         phase_next = PH_NUM;
            else                       phase_next = PH_SKIP;
          end
        end
        PH_SEPWS: begin
          if (!c_ws) begin
            if (c == CH_LA)    phase_next = PH_A;
            else if (c_starts) phase_next = PH_NUM;
            else               phase_next = PH_SKIP;
          end
        end
        PH_A:    phase_next = (c == CH_LN) ? PH_AN : PH_SKIP;
        PH_AN:   phase_next = (c == CH_LD) ? PH_AND : PH_SKIP;
        PH_AND: begin
          if (c_ws)          phase_next = PH_LEAD;
          else if (c_starts) phase_next = PH_NUM;
          else               phase_next = PH_SKIP;
        end
        default: phase_next = PH_SKIP;
      endcase
    end
  end

  // Actions taken on the current byte.
  always_comb begin
    act_begin = 1'b0;
    act_digit = 1'b0;
    act_unit  = 1'b0;
    fin_add   = 1'b0;
    fin_ok    = !error_seen;
    if (at_end) begin
      if ((phase == PH_NUM && digits_seen) || phase == PH_POSTWS) begin
        fin_add = 1'b1;
      end else if (!(phase inside {PH_WORD, PH_SEPWS, PH_AND})) begin
        fin_ok = 1'b0;
      end
    end else begin
      case (phase)
        PH_LEAD:   act_begin = c_starts;
        PH_NUM: begin
          act_digit = c_digit;
          act_unit  = !c_digit && digits_seen && !c_ws && c_has_unit;
        end
        PH_POSTWS: act_unit  = !c_ws && c_has_unit;
        PH_WORD:   act_begin = !c_letter && !(c == CH_COMMA || c_ws) && c_starts;
        PH_SEPWS:  act_begin = !c_ws && (c != CH_LA) && c_starts;
        PH_AND:    act_begin = !c_ws && c_starts;
        default:   act_begin = 1'b0;
      endcase
    end
  end

  // Decimal accumulation: value times ten plus the new digit.
  assign term_digit  = (term_value << 3) + (term_value << 1) + c_val;
  assign term_signed = negative_term ? (VALUE_BITS'(0) - term_value) : term_value;

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      negative_term <= 1'b0;
      digits_seen   <= 1'b0;
      term_value    <= '0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      if (at_end) begin
        phase         <= PH_LEAD;
        negative_term <= 1'b0;
        digits_seen   <= 1'b0;
        term_value    <= '0;
        error_seen    <= 1'b0;
      end else begin
        phase      <= phase_next;
        error_seen <= error_seen || (phase_next == PH_SKIP);
        if (act_begin) begin
          negative_term <= (c == CH_MINUS);
          digits_seen   <= c_digit;
          term_value    <= c_digit ? c_val : '0;
        end else if (act_digit) begin
          digits_seen <= 1'b1;
          term_value  <= term_digit;
        end
      end
    end
  end

  // Event register toward the scaling stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (accept) begin
      ev_valid <= 1'b1;
    end else if (ev_ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev.add  <= act_unit || fin_add;
      ev.last <= at_end;
      ev.ok   <= fin_ok;
      ev.unit <= fin_add ? U_SEC : c_unit;
      ev.term <= term_signed;
    end
  end

endmodule

/* sv/dtp_scale.sv */
// ----------------------------------------------------------------------------
// dtp_scale
// Multiplies each completed term by its unit factor in seconds and registers
// the product; bytes that neither end a term nor the text are dropped here.
// ----------------------------------------------------------------------------
module dtp_scale (
  input  logic            clk,
  input  logic            rst,
  input  dtp_pkg::event_t ev,
  input  logic            ev_valid,
  output logic            ev_ready,
  output dtp_pkg::prod_t  pr,
  output logic            pr_valid,
  input  logic            pr_ready
);
  import dtp_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + FACTOR_BITS;

  logic                  take;
  logic [PROD_BITS-1:0]  full;

  assign ev_ready = !pr_valid || pr_ready;
  assign take     = ev_valid && ev_ready;

  // Single multiplier; the product wraps at the value width.
  assign full = PROD_BITS'(ev.term) * PROD_BITS'(unit_factor(ev.unit));

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (take) begin
      pr_valid <= ev.add || ev.last;
    end else if (pr_ready) begin
      pr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pr.last  <= ev.last;
      pr.ok    <= ev.ok;
      pr.value <= ev.add ? full[VALUE_BITS-1:0] : '0;
    end
  end

endmodule

/* sv/dtp_accum.sv */
// ----------------------------------------------------------------------------
// dtp_accum
// Sums scaled terms into the running total and, at end of text, loads the
// output result register.
// ----------------------------------------------------------------------------
module dtp_accum (
  input  logic           clk,
  input  logic           rst,
  input  dtp_pkg::prod_t pr,
  input  logic           pr_valid,
  output logic           pr_ready,
  dtp_result_if.source   result
);
  import dtp_pkg::*;

  logic [VALUE_BITS-1:0] running_total;
  logic [VALUE_BITS-1:0] sum;
  logic                  out_free;
  logic                  consume;

  // Terms always drain; an end marker waits for a free result register.
  assign out_free = !result.valid || result.ready;
  assign pr_ready = !pr.last || out_free;
  assign consume  = pr_valid && pr_ready;
  assign sum      = running_total + pr.value;

  // Running total, cleared at every end of text.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (consume) begin
      running_total <= pr.last ? '0 : sum;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (consume && pr.last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && pr.last) begin
      result.total_seconds <= pr.ok ? to_out(sum) : '0;
      result.parse_error   <= !pr.ok;
    end
  end

endmodule

/* sv/duration_text_parser.sv */
// ----------------------------------------------------------------------------
// duration_text_parser
// Parses a duration text such as "1h 30m" into total seconds.
// ----------------------------------------------------------------------------
// Usage:
//   The text channel takes one character per transaction; a zero byte ends
//   the text and produces exactly one transaction on the result channel with
//   the total in seconds and an error flag (total is zero on error). Other
//   bytes produce no result.
//   Throughput is one byte per cycle while text ready is high. A byte
//   passes three registers: the parser state and event register, the
//   unit multiplier register and the accumulator with the result
//   register, in that order, before its result shows.
//   The multiplier stage sets the cycle time: one term times one constant.
//   When the receiver stalls, bytes are still taken and summed; only a
//   second end of text waits in the multiplier register. Once it does, the
//   event register takes one more byte and then the text channel holds ready
//   low until the result register is taken.
//   Reset clears the parser to the start of a text, zeroes the running total
//   and empties every stage.
// ----------------------------------------------------------------------------
module duration_text_parser (
  input  logic         clk,
  input  logic         rst,
  dtp_byte_if.sink     text,
  dtp_result_if.source result
);
  import dtp_pkg::*;

  event_t ev;
  logic   ev_valid;
  logic   ev_ready;
  prod_t  pr;
  logic   pr_valid;
  logic   pr_ready;

  dtp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .ev       (ev),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready)
  );

  dtp_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .pr       (pr),
    .pr_valid (pr_valid),
    .pr_ready (pr_ready)
  );

  dtp_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .pr       (pr),
    .pr_valid (pr_valid),
    .pr_ready (pr_ready),
    .result   (result)
  );

endmodule

/* sv/dtp_checker.sv */
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks for the duration text parser, bound to the top level.
// ----------------------------------------------------------------------------
module dtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        text_valid,
  input logic        text_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] total_seconds,
  input logic        parse_error
);

  // A stalled result transaction holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(total_seconds) && $stable(parse_error))
    else $error("result changed while stalled");

  // An error result always reports a zero total.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_error |-> total_seconds == 32'd0)
    else $error("error result with nonzero total");

  // With the result register empty nothing can block the text channel.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> text_ready)
    else $error("text channel stalled with empty result register");

  // Coming out of reset the block takes text and shows no result.
  a_reset_state: assert property (@(posedge clk)
    $past(rst) && !rst |-> text_ready && !result_valid)
    else $error("bad state after reset");

endmodule

bind duration_text_parser dtp_checker u_dtp_checker (
  .clk           (clk),
  .rst           (rst),
  .text_valid    (text.valid),
  .text_ready    (text.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .total_seconds (result.total_seconds),
  .parse_error   (result.parse_error)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the duration text parser. A table of short texts
// covers the extremes, every unit and separator and each kind of error, and
// generated texts follow: mostly well-formed terms with random content, plus
// mutated and noise texts. A cycle-free predictor computes the total and the
// error flag of every text, and each result transaction is compared with the
// oldest pending prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  // One result transaction as predicted or observed.
  typedef struct packed {
    logic signed [31:0] secs;
    logic               bad;
  } verdict_t;

  // A directed row either carries a hand-written result or defers to the predictor.
  typedef struct packed {
    bit                 typed;
    logic signed [31:0] secs;
    logic               bad;
  } row_check_t;

  localparam bit CHECK_TYPED = 1'b1;
  localparam bit CHECK_MODEL = 1'b0;
  localparam int N_DIRECTED  = 25;
  localparam int RANDOM_BYTES = 850;

  logic clk = 1'b0;
  logic rst;

  dtp_byte_if   text_ch ();
  dtp_result_if result_ch ();

  duration_text_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed texts; each is followed by a zero byte when played.
  string directed_text [N_DIRECTED] = '{
    "",                          // empty text
    " \t ",                      // blank text
    "0s",
    "1y",                        // largest unit
    "1W 2D",                     // upper-case units
    "3h, and 4m and 5s",         // comma and the word and
    "-5m",
    "+7",                        // bare number as the last term
    "12 s",                      // whitespace before the unit
    "4294967295s",               // wraps to minus one
    "1hours30minutes",           // rest of the unit word skipped
    "+",                         // sign without digits
    "--1s",                      // two signs
    "5x",                        // unknown unit letter
    "1h,,2m",                    // second comma
    "12,s",                      // comma right after digits
    "1h an 2m",                  // partial and
    "1h and ",                   // whitespace after and at the end
    "1h and",                    // and at the very end is fine
    "\377",                      // non-ASCII byte
    "\t1d\n\0132h\014\r",        // every whitespace code
    "5 5s",                      // bare number not last
    "2147483648s",               // most negative total
    "1h and-2m 7",
    "?9s"                        // unknown leading character
  };

  row_check_t directed_check [N_DIRECTED] = '{
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b0},
    '{CHECK_TYPED, 32'sd31536000, 1'b0},
    '{CHECK_MODEL, 32'sd0, 1'b0},
    '{CHECK_MODEL, 32'sd0, 1'b0},
    '{CHECK_TYPED, -32'sd300, 1'b0},
    '{CHECK_TYPED, 32'sd7, 1'b0},
    '{CHECK_TYPED, 32'sd12, 1'b0},
    '{CHECK_TYPED, -32'sd1, 1'b0},
    '{CHECK_MODEL, 32'sd0, 1'b0},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sd3600, 1'b0},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_MODEL, 32'sd0, 1'b0},
    '{CHECK_TYPED, 32'sd0, 1'b1},
    '{CHECK_TYPED, 32'sh80000000, 1'b0},
    '{CHECK_MODEL, 32'sd0, 1'b0},
    '{CHECK_TYPED, 32'sd0, 1'b1}
  };

  // Parser state as the predictor sees it.
  phase_t                phase_q;
  logic                  negative_q;
  logic                  have_digits;
  logic [VALUE_BITS-1:0] term_acc;
  logic [VALUE_BITS-1:0] run_total;
  logic                  seen_error;

  verdict_t   awaited_totals [$];
  logic [7:0] text_q [$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  bit         sender_calm = 1'b0;
  bit         sink_calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit blank_char(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit decimal_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Seconds per unit letter; zero means the byte is no unit.
  function automatic logic [VALUE_BITS-1:0] unit_seconds(input logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    case (lc)
      "y":     return VALUE_BITS'(365 * 24 * 3600);
      "w":     return VALUE_BITS'(7 * 24 * 3600);
      "d":     return VALUE_BITS'(24 * 3600);
      "h":     return VALUE_BITS'(3600);
      "m":     return VALUE_BITS'(60);
      "s":     return VALUE_BITS'(1);
      default: return '0;
    endcase
  endfunction

  function automatic void clear_parser();
    phase_q     = PH_LEAD;
    negative_q  = 1'b0;
    have_digits = 1'b0;
    term_acc    = '0;
    run_total   = '0;
    seen_error  = 1'b0;
  endfunction

  // Adds the current term, signed, times the unit factor; wraps at VALUE_BITS.
  function automatic void add_scaled(input logic [VALUE_BITS-1:0] factor);
    logic [VALUE_BITS-1:0] t;
    t = term_acc;
    if (negative_q) t = -t;
    run_total = run_total + t * factor;
  endfunction

  function automatic void open_term(input logic [7:0] c);
    negative_q  = (c == "-");
    have_digits = decimal_char(c);
    term_acc    = have_digits ? VALUE_BITS'(c - "0") : '0;
    phase_q     = PH_NUM;
  endfunction

  function automatic void mark_error();
    seen_error = 1'b1;
    phase_q    = PH_SKIP;
  endfunction

  // Advances the parse by one byte; a zero byte closes the text with a verdict.
  function automatic void track_duration(input logic [7:0] c, output bit ended,
                                         output verdict_t v);
    bit starts;
    bit ok;
    ended  = 1'b0;
    v      = '0;
    starts = decimal_char(c) || c == "+" || c == "-";
    if (c == 8'h00) begin
      ok = !seen_error;
      if ((phase_q == PH_NUM && have_digits) || phase_q == PH_POSTWS) begin
        add_scaled(VALUE_BITS'(1));
      end else if (phase_q != PH_WORD && phase_q != PH_SEPWS && phase_q != PH_AND) begin
        ok = 1'b0;
      end
      if (ok) begin
        v.secs = 32'(signed'(run_total));
        v.bad  = 1'b0;
      end else begin
        v.secs = '0;
        v.bad  = 1'b1;
      end
      ended = 1'b1;
      clear_parser();
      return;
    end
    case (phase_q)
      PH_LEAD: begin
        if (!blank_char(c)) begin
          if (starts) open_term(c);
          else mark_error();
        end
      end
      PH_NUM: begin
        if (decimal_char(c)) begin
          term_acc    = term_acc * VALUE_BITS'(10) + VALUE_BITS'(c - "0");
          have_digits = 1'b1;
        end else if (!have_digits) begin
          mark_error();
        end else if (blank_char(c)) begin
          phase_q = PH_POSTWS;
        end else if (unit_seconds(c) != '0) begin
          add_scaled(unit_seconds(c));
          phase_q = PH_WORD;
        end else begin
          mark_error();
        end
      end
      PH_POSTWS: begin
        if (!blank_char(c)) begin
          if (unit_seconds(c) != '0) begin
            add_scaled(unit_seconds(c));
            phase_q = PH_WORD;
          end else begin
            mark_error();
          end
        end
      end
      PH_WORD: begin
        if (!alpha_char(c)) begin
          if (c == "," || blank_char(c)) phase_q = PH_SEPWS;
          else if (starts) open_term(c);
          else mark_error();
        end
      end
      PH_SEPWS: begin
        if (!blank_char(c)) begin
          if (c == "a") phase_q = PH_A;
          else if (starts) open_term(c);
          else mark_error();
        end
      end
      PH_A: begin
        if (c == "n") phase_q = PH_AN;
        else mark_error();
      end
      PH_AN: begin
        if (c == "d") phase_q = PH_AND;
        else mark_error();
      end
      PH_AND: begin
        if (blank_char(c)) phase_q = PH_LEAD;
        else if (starts) open_term(c);
        else mark_error();
      end
      default: begin
        phase_q = PH_SKIP;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Text channel driver
  // ---------------------------------------------------------------------------

  // Offers one byte after a random gap and returns once the transaction is taken.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 23) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  // Sends the text in text_q plus the closing zero and records the verdict.
  task automatic play_text(input bit use_typed, input verdict_t typed_val);
    bit       ended;
    verdict_t v;
    text_q.push_back(8'h00);
    foreach (text_q[i]) begin
      put_byte(text_q[i]);
      track_duration(text_q[i], ended, v);
      if (ended) awaited_totals.push_back(use_typed ? typed_val : v);
    end
  endtask

  // Holds the sender off until every pending result has arrived.
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_totals.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  task automatic push_blanks();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(9, 13)));
      else text_q.push_back(8'd32);
    end
  endtask

  task automatic push_and();
    text_q.push_back("a");
    text_q.push_back("n");
    text_q.push_back("d");
  endtask

  // Builds one text: mostly well-formed terms, some mutated, a few pure noise.
  task automatic compose_text();
    string      units;
    int         roll;
    int         terms;
    int         pos;
    logic [7:0] u;
    units = "ywdhms";
    text_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    terms = $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) push_blanks();
    for (int k = 0; k < terms; k++) begin
      if ($urandom_range(0, 3) == 0) text_q.push_back($urandom_range(0, 1) ? "-" : "+");
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4))
        text_q.push_back(8'($urandom_range(48, 57)));
      // A bare number may close the text.
      if (k == terms - 1 && $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 2) == 0) push_blanks();
        break;
      end
      if ($urandom_range(0, 3) == 0) push_blanks();
      u = units[$urandom_range(0, 5)];
      text_q.push_back($urandom_range(0, 1) ? u - 8'd32 : u);
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          u = 8'($urandom_range(97, 122));
          text_q.push_back($urandom_range(0, 1) ? u - 8'd32 : u);
        end
      end
      if (k < terms - 1) begin
        case ($urandom_range(0, 4))
          0: ;
          1: push_blanks();
          2: begin
            text_q.push_back(",");
            if ($urandom_range(0, 1) == 0) push_blanks();
          end
          3: begin
            push_blanks();
            push_and();
            if ($urandom_range(0, 1) == 0) push_blanks();
          end
          default: begin
            text_q.push_back(",");
            push_blanks();
            push_and();
            push_blanks();
          end
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: push_blanks();
          1: begin
            push_blanks();
            push_and();
          end
          default: ;
        endcase
      end
    end
    // Break some texts by replacing, inserting or dropping one byte.
    if (roll < 30) begin
      pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
      if (text_q.size() == 0) begin
        text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        case ($urandom_range(0, 2))
          0:       text_q[pos] = 8'($urandom_range(1, 255));
          1:       text_q.insert(pos, 8'($urandom_range(1, 255)));
          default: text_q.delete(pos);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result channel receiver and checker
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    int       stall;
    verdict_t want;
    result_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      // A result transaction was taken at this edge.
      if (awaited_totals.size() == 0) begin
        log_mismatch($sformatf("result with nothing pending: total %0d error %0b",
                               result_ch.total_seconds, result_ch.parse_error));
      end else begin
        want = awaited_totals.pop_front();
        if (result_ch.total_seconds !== want.secs)
          log_mismatch($sformatf("total_seconds %0d, predicted %0d",
                                 result_ch.total_seconds, want.secs));
        if (result_ch.parse_error !== want.bad)
          log_mismatch($sformatf("parse_error %0b, predicted %0b",
                                 result_ch.parse_error, want.bad));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    verdict_t tv;
    int       waited;
    rst               = 1'b1;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = 8'h00;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int r = 0; r < N_DIRECTED; r++) begin
      text_q.delete();
      for (int i = 0; i < directed_text[r].len(); i++) text_q.push_back(directed_text[r][i]);
      tv.secs = directed_check[r].secs;
      tv.bad  = directed_check[r].bad;
      play_text(directed_check[r].typed, tv);
    end
    drain_results();

    // Generated texts, with an occasional full drain in between.
    while (bytes_sent < RANDOM_BYTES) begin
      compose_text();
      play_text(CHECK_MODEL, '0);
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    // Wait for the last results, then give the pipeline time to show strays.
    text_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (awaited_totals.size() != 0 && waited < 5000);
    if (awaited_totals.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", awaited_totals.size()));
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
sv/dtp_pkg.sv
sv/dtp_byte_if.sv
sv/dtp_result_if.sv
sv/dtp_parser.sv
sv/dtp_scale.sv
sv/dtp_accum.sv
sv/duration_text_parser.sv
sv/dtp_checker.sv
tb/testbench.sv
